// ===== rtl/calendar_clock_with_zone_shift_macros.svh =====
// Assertion macros shared by the calendar clock RTL.
`ifndef CALENDAR_CLOCK_WITH_ZONE_SHIFT_MACROS_SVH
`define CALENDAR_CLOCK_WITH_ZONE_SHIFT_MACROS_SVH

// Consequent must hold on the same clock edge as the antecedent.
`define CCZ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold on the clock edge after the antecedent.
`define CCZ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/ccz_pkg.sv =====
// Types, constants and calendar helper functions of the calendar clock.
package ccz_pkg;

  localparam int ELAPSED_BITS_DEFAULT = 16;
  localparam int SHIFT_COUNT_BITS     = 16;
  localparam int BCD_FIELDS_BITS      = 48;
  localparam int OUT_DATA_BITS        = 48;
  localparam int CENTURY_COUNT        = 41;
  localparam int QUAD_CENTURY_COUNT   = 11;

  localparam logic [11:0] YEAR_BASE    = 12'd2000;
  localparam logic [7:0]  SEC_LAST     = 8'd59;
  localparam logic [7:0]  MIN_LAST     = 8'd59;
  localparam logic [7:0]  HOUR_LAST    = 8'd23;
  localparam logic [3:0]  MONTH_FIRST  = 4'd1;
  localparam logic [3:0]  MONTH_LAST   = 4'd12;
  localparam logic [4:0]  DAY_FIRST    = 5'd1;
  localparam logic [7:0]  MONTH_MASK   = 8'h7F;

  localparam logic signed [11:0] BASE_OFFSET = 12'sd540;
  localparam logic signed [11:0] DST_MINUTES = 12'sd60;
  localparam logic [10:0] ZONE_RESET = 11'd540;

  typedef enum logic {
    CMD_SEED    = 1'b0,
    CMD_ADVANCE = 1'b1
  } ccz_op_t;

  typedef enum logic [1:0] {
    REG_ZONE_OFFSET = 2'd0,
    REG_DAYLIGHT    = 2'd1,
    REG_SETTINGS    = 2'd2
  } ccz_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_SEED,
    ST_ZONE,
    ST_FWD,
    ST_BACK,
    ST_FINISH
  } ccz_state_t;

  typedef struct packed {
    ccz_op_t    cmd;
    logic       read_ok;
    logic [7:0] bcd_year;
    logic [7:0] bcd_month;
    logic [7:0] bcd_day;
    logic [7:0] bcd_hour;
    logic [7:0] bcd_minute;
    logic [7:0] bcd_second;
  } ccz_item_t;

  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [7:0]  hour;
    logic [7:0]  minute;
    logic [7:0]  second;
  } ccz_time_t;

  typedef struct packed {
    logic [10:0] zone_offset_raw;
    logic        dst_enable;
    logic        settings_present;
  } ccz_cfg_t;

  typedef struct packed {
    logic capture;
    logic seed_load;
    logic zone_load;
    logic adv_load;
    logic invalidate;
    logic step_fwd;
    logic step_back;
  } ccz_cmd_t;

  typedef struct packed {
    ccz_op_t item_cmd;
    logic    item_read_ok;
    logic    clock_valid;
    logic    delta_neg;
    logic    count_zero;
  } ccz_status_t;

  // Each BCD digit taken at face value: high * 10 + low.
  function automatic logic [7:0] bcd_decode(logic [7:0] b);
    logic [7:0] hi;
    hi = {4'b0, b[7:4]};
    return (hi << 3) + (hi << 1) + {4'b0, b[3:0]};
  endfunction

  // Gregorian rule over the 12-bit year range, by comparison with the
  // century marks.
  function automatic logic is_leap(logic [11:0] year);
    logic cent;
    logic quad;
    cent = 1'b0;
    quad = 1'b0;
    for (int k = 0; k < CENTURY_COUNT; k++) begin
      if (year == 12'(k * 100)) cent = 1'b1;
    end
    for (int k = 0; k < QUAD_CENTURY_COUNT; k++) begin
      if (year == 12'(k * 400)) quad = 1'b1;
    end
    return quad || ((year[1:0] == 2'b00) && !cent);
  endfunction

  function automatic logic [4:0] days_in_month(logic [11:0] year, logic [3:0] month);
    logic [4:0] d;
    case (month)
      4'd2:    d = is_leap(year) ? 5'd29 : 5'd28;
      4'd4:    d = 5'd30;
      4'd6:    d = 5'd30;
      4'd9:    d = 5'd30;
      4'd11:   d = 5'd30;
      default: d = 5'd31;
    endcase
    return d;
  endfunction

endpackage

// ===== rtl/calendar_clock_with_zone_shift.sv =====
// Top level of the calendar clock with time-zone shift.
// Throughput: one word at a time; a seed walks its zone shift, forward in seconds
// or backward in minutes, and an advance walks its N seconds, while a failed seed or
// an advance of an invalid clock takes no steps, all set by the one-step-per-cycle
// calendar counter.
// Reset (rst, synchronous) clears the clock to the start of year 2000, invalid.

// A seed word loads the time from a BCD reading, clamps month and day, and then
// walks the zone shift: forward one second per cycle, backward one minute per
// cycle. An advance word steps the clock one second per cycle. Every word gives
// one result word showing the clock afterwards. The result sits in an output
// register, so the sequencer returns to idle as soon as the register is free,
// and a new input word can be taken while the previous result still waits.
// Configuration writes are always accepted and take effect on the next seed.
module calendar_clock_with_zone_shift
  import ccz_pkg::*;
#(
  parameter int ELAPSED_BITS = ELAPSED_BITS_DEFAULT
) (
  input  logic clk,
  input  logic rst,

  // Input word stream.
  input  logic s_tvalid,
  output logic s_tready,
  // tdata, low bits first: bcd_year[7:0], bcd_month[15:8], bcd_day[23:16],
  // bcd_hour[31:24], bcd_minute[39:32], bcd_second[47:40],
  // adv_seconds[48 +: ELAPSED_BITS], zero fill to a whole byte.
  input  logic [((BCD_FIELDS_BITS + ELAPSED_BITS + 7) / 8) * 8 - 1:0] s_tdata,
  // tuser, low bit first: cmd, read_ok.
  input  logic [1:0] s_tuser,

  // Result word stream.
  output logic m_tvalid,
  input  logic m_tready,
  // tdata, low bits first: year_out[11:0], month_out[15:12], day_out[20:16],
  // hour_out[28:21], minute_out[36:29], second_out[44:37], zero fill.
  output logic [OUT_DATA_BITS-1:0] m_tdata,
  // tuser: clock_ok.
  output logic m_tuser,

  // Configuration write channel.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [10:0] cfg_data
);

  `include "calendar_clock_with_zone_shift_macros.svh"

  ccz_cfg_t    cfg;
  ccz_item_t   item;
  ccz_cmd_t    cmd;
  ccz_status_t status;
  ccz_time_t   time_cur;
  ccz_time_t   out_time;
  logic        clock_valid;
  logic        result_load;
  logic        out_free;
  logic        out_ok;
  logic        month_legal;

  // Configuration registers; an index beyond the list is dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.zone_offset_raw  <= ZONE_RESET;
      cfg.dst_enable       <= 1'b0;
      cfg.settings_present <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ZONE_OFFSET: cfg.zone_offset_raw  <= cfg_data;
        REG_DAYLIGHT:    cfg.dst_enable       <= cfg_data[0];
        REG_SETTINGS:    cfg.settings_present <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Unpack the input word.
  assign item.cmd        = ccz_op_t'(s_tuser[0]);
  assign item.read_ok    = s_tuser[1];
  assign item.bcd_year   = s_tdata[7:0];
  assign item.bcd_month  = s_tdata[15:8];
  assign item.bcd_day    = s_tdata[23:16];
  assign item.bcd_hour   = s_tdata[31:24];
  assign item.bcd_minute = s_tdata[39:32];
  assign item.bcd_second = s_tdata[47:40];

  ccz_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .status      (status),
    .out_free    (out_free),
    .cmd         (cmd),
    .result_load (result_load)
  );

  ccz_datapath #(
    .ELAPSED_BITS (ELAPSED_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .item        (item),
    .adv_seconds (s_tdata[BCD_FIELDS_BITS +: ELAPSED_BITS]),
    .cfg         (cfg),
    .status      (status),
    .time_cur    (time_cur),
    .clock_valid (clock_valid)
  );

  // Output register: free when empty or being drained this cycle.
  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (result_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (result_load) begin
      out_time <= time_cur;
      out_ok   <= clock_valid;
    end
  end

  assign m_tuser = out_ok;
  assign m_tdata = {3'b000, out_time.second, out_time.minute, out_time.hour,
                    out_time.day, out_time.month, out_time.year};

  assign month_legal = (out_time.month >= MONTH_FIRST) && (out_time.month <= MONTH_LAST);

  `CCZ_ASSERT_NEXT(a_accept_closes, s_tvalid && s_tready, !s_tready, "input taken while busy")
  `CCZ_ASSERT_NOW(a_load_free, result_load, !m_tvalid || m_tready, "result overwritten")
  `CCZ_ASSERT_NOW(a_month_range, m_tvalid, month_legal, "month out of range")
  `CCZ_ASSERT_NOW(a_day_nonzero, m_tvalid, out_time.day != 5'd0, "day is zero")

endmodule

// ===== rtl/ccz_ctrl.sv =====
// Sequencer of the calendar clock: walks one word through seed, shift and step phases.
module ccz_ctrl
  import ccz_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  ccz_status_t status,
  input  logic        out_free,
  output ccz_cmd_t    cmd,
  output logic        result_load
);

  ccz_state_t state;
  ccz_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    cmd         = '0;
    in_ready    = 1'b0;
    result_load = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        if (status.item_cmd == CMD_SEED) begin
          if (status.item_read_ok) begin
            state_next = ST_SEED;
          end else begin
            cmd.invalidate = 1'b1;
            state_next     = ST_FINISH;
          end
        end else if (status.clock_valid) begin
          cmd.adv_load = 1'b1;
          state_next   = ST_FWD;
        end else begin
          state_next = ST_FINISH;
        end
      end
      ST_SEED: begin
        cmd.seed_load = 1'b1;
        state_next    = ST_ZONE;
      end
      ST_ZONE: begin
        cmd.zone_load = 1'b1;
        state_next    = status.delta_neg ? ST_BACK : ST_FWD;
      end
      ST_FWD: begin
        if (status.count_zero) begin
          state_next = ST_FINISH;
        end else begin
          cmd.step_fwd = 1'b1;
        end
      end
      ST_BACK: begin
        if (status.count_zero) begin
          state_next = ST_FINISH;
        end else begin
          cmd.step_back = 1'b1;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          result_load = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/ccz_datapath.sv =====
// Calendar registers, BCD seed decode, zone offset and the step counter.
module ccz_datapath
  import ccz_pkg::*;
#(
  parameter int ELAPSED_BITS = ELAPSED_BITS_DEFAULT
) (
  input  logic                    clk,
  input  logic                    rst,
  input  ccz_cmd_t                cmd,
  input  ccz_item_t               item,
  input  logic [ELAPSED_BITS-1:0] adv_seconds,
  input  ccz_cfg_t                cfg,
  output ccz_status_t             status,
  output ccz_time_t               time_cur,
  output logic                    clock_valid
);

  localparam int CNT_BITS =
    (ELAPSED_BITS > SHIFT_COUNT_BITS) ? ELAPSED_BITS : SHIFT_COUNT_BITS;

  ccz_item_t               item_reg;
  logic [ELAPSED_BITS-1:0] elapsed_reg;
  logic [CNT_BITS-1:0]     count;

  ccz_time_t          seed_time;
  ccz_time_t          fwd_time;
  ccz_time_t          back_time;
  logic [7:0]         month_dec;
  logic [7:0]         day_dec;
  logic [4:0]         seed_dim;
  logic [4:0]         cur_dim;
  logic [4:0]         prev_dim;
  logic [3:0]         prev_month;
  logic [11:0]        prev_year;
  logic signed [11:0] zone_offset;
  logic signed [11:0] zone_delta;
  logic [11:0]        back_minutes;
  logic [15:0]        fwd_minutes;
  logic [15:0]        fwd_seconds;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_reg    <= item;
      elapsed_reg <= adv_seconds;
    end
  end

  // Seed decode: month clamped to 1..12, day clamped against the month length of the decoded year.
  always_comb begin
    seed_time.year   = YEAR_BASE + {4'b0, bcd_decode(item_reg.bcd_year)};
    month_dec        = bcd_decode(item_reg.bcd_month & MONTH_MASK);
    if (month_dec == 8'd0) begin
      seed_time.month = MONTH_FIRST;
    end else if (month_dec > {4'b0, MONTH_LAST}) begin
      seed_time.month = MONTH_LAST;
    end else begin
      seed_time.month = month_dec[3:0];
    end
    seed_dim = days_in_month(seed_time.year, seed_time.month);
    day_dec  = bcd_decode(item_reg.bcd_day);
    if (day_dec == 8'd0) begin
      seed_time.day = DAY_FIRST;
    end else if (day_dec > {3'b0, seed_dim}) begin
      seed_time.day = seed_dim;
    end else begin
      seed_time.day = day_dec[4:0];
    end
    seed_time.hour   = bcd_decode(item_reg.bcd_hour);
    seed_time.minute = bcd_decode(item_reg.bcd_minute);
    seed_time.second = bcd_decode(item_reg.bcd_second);
  end

  // Zone shift in minutes relative to the base offset.
  always_comb begin
    if (cfg.settings_present) begin
      zone_offset = {cfg.zone_offset_raw[10], cfg.zone_offset_raw}
                  + (cfg.dst_enable ? DST_MINUTES : 12'sd0);
    end else begin
      zone_offset = BASE_OFFSET;
    end
    zone_delta   = zone_offset - BASE_OFFSET;
    back_minutes = 12'(-zone_delta);
    fwd_minutes  = {4'b0, zone_delta};
    fwd_seconds  = (fwd_minutes << 6) - (fwd_minutes << 2);
  end

  // One second forward with carries up to the year.
  always_comb begin
    cur_dim  = days_in_month(time_cur.year, time_cur.month);
    fwd_time = time_cur;
    if (time_cur.second < SEC_LAST) begin
      fwd_time.second = time_cur.second + 8'd1;
    end else begin
      fwd_time.second = 8'd0;
      if (time_cur.minute < MIN_LAST) begin
        fwd_time.minute = time_cur.minute + 8'd1;
      end else begin
        fwd_time.minute = 8'd0;
        if (time_cur.hour < HOUR_LAST) begin
          fwd_time.hour = time_cur.hour + 8'd1;
        end else begin
          fwd_time.hour = 8'd0;
          if (time_cur.day < cur_dim) begin
            fwd_time.day = time_cur.day + 5'd1;
          end else begin
            fwd_time.day = DAY_FIRST;
            if (time_cur.month < MONTH_LAST) begin
              fwd_time.month = time_cur.month + 4'd1;
            end else begin
              fwd_time.month = MONTH_FIRST;
              fwd_time.year  = time_cur.year + 12'd1;
            end
          end
        end
      end
    end
  end

  // One minute backward; a day borrow lands on the last day of the prior month.
  always_comb begin
    if (time_cur.month > MONTH_FIRST) begin
      prev_month = time_cur.month - 4'd1;
      prev_year  = time_cur.year;
    end else begin
      prev_month = MONTH_LAST;
      prev_year  = time_cur.year - 12'd1;
    end
    prev_dim  = days_in_month(prev_year, prev_month);
    back_time = time_cur;
    if (time_cur.minute != 8'd0) begin
      back_time.minute = time_cur.minute - 8'd1;
    end else begin
      back_time.minute = MIN_LAST;
      if (time_cur.hour != 8'd0) begin
        back_time.hour = time_cur.hour - 8'd1;
      end else begin
        back_time.hour = HOUR_LAST;
        if (time_cur.day > DAY_FIRST) begin
          back_time.day = time_cur.day - 5'd1;
        end else begin
          back_time.month = prev_month;
          back_time.year  = prev_year;
          back_time.day   = prev_dim;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clock_valid     <= 1'b0;
      time_cur.year   <= YEAR_BASE;
      time_cur.month  <= MONTH_FIRST;
      time_cur.day    <= DAY_FIRST;
      time_cur.hour   <= 8'd0;
      time_cur.minute <= 8'd0;
      time_cur.second <= 8'd0;
      count           <= '0;
    end else begin
      if (cmd.invalidate) clock_valid <= 1'b0;
      if (cmd.seed_load) time_cur <= seed_time;
      if (cmd.zone_load) begin
        clock_valid <= 1'b1;
        if (zone_delta[11]) begin
          count <= CNT_BITS'(back_minutes);
        end else begin
          count <= CNT_BITS'(fwd_seconds);
        end
      end
      if (cmd.adv_load) count <= CNT_BITS'(elapsed_reg);
      if (cmd.step_fwd) begin
        time_cur <= fwd_time;
        count    <= count - CNT_BITS'(1);
      end
      if (cmd.step_back) begin
        time_cur <= back_time;
        count    <= count - CNT_BITS'(1);
      end
    end
  end

  assign status.item_cmd     = item_reg.cmd;
  assign status.item_read_ok = item_reg.read_ok;
  assign status.clock_valid  = clock_valid;
  assign status.delta_neg    = zone_delta[11];
  assign status.count_zero   = (count == '0);

endmodule
